@@ hw/rtl/rfu_pkg.sv @@
// rfu_pkg: shared types and constants of the record field unpacker
// no dependencies; used by the output interface, the front end, the queue and the top level

package rfu_pkg;

  localparam int MAX_FIELDS  = 8;
  localparam int LENGTH_BITS = 16;
  localparam int FIELD_BITS  = $clog2(MAX_FIELDS);
  localparam int COUNT_BITS  = 4;
  localparam int KINDS_BITS  = 2 * MAX_FIELDS;
  localparam int PARAMS_BITS = 8 * MAX_FIELDS;
  localparam int CFG_BITS    = PARAMS_BITS;

  // depth of the queue between front end and output side
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    REG_FIELD_COUNT  = 2'd0,
    REG_FIELD_KINDS  = 2'd1,
    REG_FIELD_PARAMS = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    KIND_FIXED   = 2'd0,
    KIND_DELIM   = 2'd1,
    KIND_PREFIX  = 2'd2,
    KIND_PREFIX2 = 2'd3
  } field_kind_t;

  typedef enum logic [1:0] {
    STATUS_OK            = 2'd0,
    STATUS_MISSING_DELIM = 2'd1,
    STATUS_SHORT_RECORD  = 2'd2,
    STATUS_EXTRA_BYTE    = 2'd3
  } status_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] field_number;
    logic [7:0]            data_out;
    logic                  byte_valid;
    logic                  field_done;
    logic                  record_done;
    status_t               status;
  } result_t;

endpackage

@@ hw/rtl/rfu_if.sv @@
// rfu_if: valid/ready channels for record bytes and unpacked results
// depends on rfu_pkg

interface rfu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] record_byte;
  logic       last_of_record;

  modport source (output valid, output record_byte, output last_of_record, input ready);
  modport sink (input valid, input record_byte, input last_of_record, output ready);
endinterface

interface rfu_out_if;
  import rfu_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [FIELD_BITS-1:0] field_number;
  logic [7:0]            data_out;
  logic                  byte_valid;
  logic                  field_done;
  logic                  record_done;
  logic [1:0]            status;

  modport source (output valid, output field_number, output data_out, output byte_valid,
                  output field_done, output record_done, output status, input ready);
  modport sink (input valid, input field_number, input data_out, input byte_valid,
                input field_done, input record_done, input status, output ready);
endinterface

@@ hw/rtl/rfu_front.sv @@
// rfu_front: configuration registers and per-byte parse state machine
// depends on rfu_pkg and rfu_in_if; pushes one result per accepted byte

module rfu_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [1:0]                   cfg_index,
  input  logic [rfu_pkg::CFG_BITS-1:0] cfg_data,
  rfu_in_if.sink                       record,
  output logic                         push_valid,
  input  logic                         push_ready,
  output rfu_pkg::result_t             push_data
);
  import rfu_pkg::*;

  typedef enum logic [1:0] {
    PH_START,
    PH_PREFIX,
    PH_DATA,
    PH_DONE
  } phase_t;

  logic [COUNT_BITS-1:0]  field_count;
  logic [KINDS_BITS-1:0]  field_kinds;
  logic [PARAMS_BITS-1:0] field_params;

  phase_t                 phase, phase_next;
  logic [FIELD_BITS-1:0]  current_field, current_field_next;
  logic [LENGTH_BITS-1:0] bytes_left, bytes_left_next;
  logic [7:0]             prefix_low_byte, prefix_low_byte_next;

  logic [1:0]             kind;
  logic [7:0]             param;
  logic [COUNT_BITS-1:0]  count_eff;
  logic                   last_field;
  logic [7:0]             rbyte;
  logic [15:0]            prefix_len;
  logic                   valid_bit, fdone;
  logic [7:0]             data;
  status_t                status;
  logic                   take;

  assign rbyte = record.record_byte;
  assign kind  = field_kinds[{current_field, 1'b0} +: 2];
  assign param = field_params[{current_field, 3'b000} +: 8];

  // field count clamped to 1..MAX_FIELDS
  always_comb begin
    if (field_count == '0) begin
      count_eff = COUNT_BITS'(1);
    end else if (field_count > COUNT_BITS'(MAX_FIELDS)) begin
      count_eff = COUNT_BITS'(MAX_FIELDS);
    end else begin
      count_eff = field_count;
    end
  end

  assign last_field = (COUNT_BITS'(current_field) + COUNT_BITS'(1)) >= count_eff;
  assign prefix_len = {rbyte, prefix_low_byte};

  always_comb begin
    phase_next           = phase;
    current_field_next   = current_field;
    bytes_left_next      = bytes_left;
    prefix_low_byte_next = prefix_low_byte;
    valid_bit            = 1'b0;
    data                 = '0;
    fdone                = 1'b0;
    status               = STATUS_OK;

    unique case (phase)
      PH_DONE: begin
        status = STATUS_EXTRA_BYTE;
      end
      PH_START: begin
        if (kind == KIND_FIXED) begin
          valid_bit = 1'b1;
          data      = rbyte;
          // zero length counts as one
          if (param <= 8'd1) begin
            fdone = 1'b1;
          end else begin
            bytes_left_next = LENGTH_BITS'(param - 8'd1);
            phase_next      = PH_DATA;
          end
        end else if (kind == KIND_DELIM) begin
          if (rbyte == param) begin
            fdone = 1'b1;
          end else begin
            valid_bit  = 1'b1;
            data       = rbyte;
            phase_next = PH_DATA;
          end
        end else if (param <= 8'd1) begin
          if (rbyte == 8'd0) begin
            fdone = 1'b1;
          end else begin
            bytes_left_next = LENGTH_BITS'(rbyte);
            phase_next      = PH_DATA;
          end
        end else begin
          prefix_low_byte_next = rbyte;
          phase_next           = PH_PREFIX;
        end
      end
      PH_PREFIX: begin
        // second prefix byte is always the high byte
        prefix_low_byte_next = '0;
        if (LENGTH_BITS'(prefix_len) == '0) begin
          fdone = 1'b1;
        end else begin
          bytes_left_next = LENGTH_BITS'(prefix_len);
          phase_next      = PH_DATA;
        end
      end
      PH_DATA: begin
        if (kind == KIND_DELIM) begin
          if (rbyte == param) begin
            fdone = 1'b1;
          end else begin
            valid_bit = 1'b1;
            data      = rbyte;
          end
        end else begin
          valid_bit = 1'b1;
          data      = rbyte;
          if (bytes_left <= LENGTH_BITS'(1)) begin
            fdone           = 1'b1;
            bytes_left_next = '0;
          end else begin
            bytes_left_next = bytes_left - LENGTH_BITS'(1);
          end
        end
      end
      default: begin
        status = STATUS_OK;
      end
    endcase

    if (fdone) begin
      bytes_left_next = '0;
      if (last_field) begin
        phase_next = PH_DONE;
      end else begin
        current_field_next = current_field + FIELD_BITS'(1);
        phase_next         = PH_START;
      end
    end

    if (record.last_of_record) begin
      priority if (phase == PH_DONE) begin
        status = STATUS_EXTRA_BYTE;
      end else if (phase_next == PH_DONE) begin
        status = STATUS_OK;
      end else if (kind == KIND_DELIM && !fdone && phase != PH_PREFIX) begin
        status = STATUS_MISSING_DELIM;
      end else begin
        status = STATUS_SHORT_RECORD;
      end
      current_field_next   = '0;
      phase_next           = PH_START;
      bytes_left_next      = '0;
      prefix_low_byte_next = '0;
    end
  end

  assign record.ready = push_ready;
  assign push_valid   = record.valid;
  assign take         = record.valid && push_ready;

  assign push_data.field_number = current_field;
  assign push_data.data_out     = data;
  assign push_data.byte_valid   = valid_bit;
  assign push_data.field_done   = fdone;
  assign push_data.record_done  = record.last_of_record;
  assign push_data.status       = status;

  always_ff @(posedge clk) begin
    if (rst) begin
      field_count     <= COUNT_BITS'(1);
      field_kinds     <= '0;
      field_params    <= PARAMS_BITS'(1);
      phase           <= PH_START;
      current_field   <= '0;
      bytes_left      <= '0;
      prefix_low_byte <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_FIELD_COUNT:  field_count  <= cfg_data[COUNT_BITS-1:0];
          REG_FIELD_KINDS:  field_kinds  <= cfg_data[KINDS_BITS-1:0];
          REG_FIELD_PARAMS: field_params <= cfg_data[PARAMS_BITS-1:0];
          default: ;
        endcase
      end
      if (take) begin
        phase           <= phase_next;
        current_field   <= current_field_next;
        bytes_left      <= bytes_left_next;
        prefix_low_byte <= prefix_low_byte_next;
      end
    end
  end

endmodule

@@ hw/rtl/rfu_queue.sv @@
// rfu_queue: short result queue feeding the output channel
// depends on rfu_pkg and rfu_out_if

module rfu_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  rfu_pkg::result_t push_data,
  rfu_out_if.source        result
);
  import rfu_pkg::*;

  result_t              mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QPTR_BITS:0]   count;
  logic                 push, pop;
  result_t              head;

  assign push_ready = count != (QPTR_BITS + 1)'(QUEUE_DEPTH);
  assign push       = push_valid && push_ready;
  assign result.valid = count != '0;
  assign pop        = result.valid && result.ready;

  assign head                = mem[rd_ptr];
  assign result.field_number = head.field_number;
  assign result.data_out     = head.data_out;
  assign result.byte_valid   = head.byte_valid;
  assign result.field_done   = head.field_done;
  assign result.record_done  = head.record_done;
  assign result.status       = head.status;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + (QPTR_BITS + 1)'(1);
        2'b01:   count <= count - (QPTR_BITS + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hw/rtl/record_field_unpacker.sv @@
// record_field_unpacker: top level, parse front end followed by a result queue
// depends on rfu_pkg, rfu_if, rfu_front and rfu_queue
//
//   channel  | dir | handshake     | word
//   record   | in  | valid/ready   | record_byte, last_of_record
//   result   | out | valid/ready   | field_number, data_out, byte_valid, field_done,
//            |     |               | record_done, status
//   cfg      | in  | cfg_wr_en     | cfg_index, cfg_data
//
// one byte accepted per cycle while the queue has room; each byte gives one result word,
// written into the queue when the byte is taken. the next parse state is combinational
// and registered on each taken byte. a four-word queue sits between the parser and the
// output, so the input keeps flowing while results wait; record.ready drops only when
// the queue is full. synchronous reset clears parse state and queue pointers and returns
// the configuration registers to their reset values.

module record_field_unpacker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [1:0]                   cfg_index,
  input  logic [rfu_pkg::CFG_BITS-1:0] cfg_data,
  rfu_in_if.sink                       record,
  rfu_out_if.source                    result
);
  import rfu_pkg::*;

  logic    push_valid;
  logic    push_ready;
  result_t push_data;

  rfu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .record     (record),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  rfu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .result     (result)
  );

endmodule
